// ===== rtl/core/dkpb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dkpb_pkg: shared types and constants for the k-mer presence bitmap
// Sizes of the window and bitmap, command format between front and back,
// operation codes and register indexes.
// ============================================================================
package dkpb_pkg;

    // Sizing
    localparam int KMER_LEN    = 11;
    localparam int WORD_BITS   = 64;  // power of two, 8..64
    localparam int LENGTH_BITS = 32;

    localparam int SYMBOL_BITS  = 8;
    localparam int OP_BITS      = 2;
    localparam int IN_ADDR_BITS = 16;
    localparam int CODE_BITS    = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam int WIN_BITS     = 2 * KMER_LEN;
    localparam int FILL_BITS    = $clog2(KMER_LEN + 1);
    localparam int BIT_IDX_BITS = $clog2(WORD_BITS);

    localparam longint unsigned TOTAL_BITS = 64'd1 << WIN_BITS;
    localparam int NUM_WORDS = int'((TOTAL_BITS + WORD_BITS - 1) / WORD_BITS);
    localparam int MEM_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CMD_AW    = (MEM_AW > IN_ADDR_BITS) ? MEM_AW : IN_ADDR_BITS;

    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

    // Command queue
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    // Character codes
    localparam logic [SYMBOL_BITS-1:0] CHAR_A = 8'd65;
    localparam logic [SYMBOL_BITS-1:0] CHAR_C = 8'd67;
    localparam logic [SYMBOL_BITS-1:0] CHAR_G = 8'd71;
    localparam logic [SYMBOL_BITS-1:0] CHAR_T = 8'd84;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CODE_A = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CODE_C = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CODE_G = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CODE_T = 2'd3;

    typedef enum logic [OP_BITS-1:0] {
        OP_START  = 2'd0,
        OP_SYMBOL = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_SET   = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                kind;
        logic [CMD_AW-1:0]        addr;
        logic [BIT_IDX_BITS-1:0]  bit_idx;
        logic [LENGTH_BITS-1:0]   seq_len;
    } t_cmd;

    // A command with its valid flag, used on both sides of the queue
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_slot;

    typedef enum logic {
        BK_RUN   = 1'b0,
        BK_CLEAR = 1'b1
    } t_back_state;

    typedef struct packed {
        logic clearing;
        logic s2_valid;
    } t_back_status;

endpackage

// ===== rtl/core/dkpb_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dkpb_front: input side of the k-mer presence bitmap
// Holds the code registers, maps characters, shifts the window, counts the
// sequence length and turns each input word into a command for the back end.
// ============================================================================
module dkpb_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dkpb_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dkpb_pkg::CODE_BITS-1:0]      i_cfg_data,
    input  logic                                i_push,
    input  logic                                i_q_full,
    input  logic [dkpb_pkg::OP_BITS-1:0]        i_operation,
    input  logic [dkpb_pkg::SYMBOL_BITS-1:0]    i_symbol,
    input  logic [dkpb_pkg::IN_ADDR_BITS-1:0]   i_word_address,
    output dkpb_pkg::t_cmd_slot                 o_q_push
);
    import dkpb_pkg::*;

    logic [CODE_BITS-1:0]   r_code_a, r_code_c, r_code_g, r_code_t;
    logic [WIN_BITS-1:0]    r_window, n_window;
    logic [FILL_BITS-1:0]   r_fill, n_fill;
    logic [LENGTH_BITS-1:0] r_count, n_count;

    logic                     accept;
    logic [CODE_BITS-1:0]     code;
    logic [WIN_BITS+1:0]      shifted;
    logic [63:0]              kmer_ext;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !i_q_full;

    always_comb begin
        case (i_symbol)
            CHAR_A:  code = r_code_a;
            CHAR_C:  code = r_code_c;
            CHAR_G:  code = r_code_g;
            CHAR_T:  code = r_code_t;
            default: code = '0;
        endcase
    end

    assign shifted  = {r_window, code};
    assign kmer_ext = 64'(shifted[WIN_BITS-1:0]);

    always_comb begin
        n_window = r_window;
        n_fill   = r_fill;
        n_count  = r_count;
        o_q_push = '0;
        o_q_push.cmd.seq_len = r_count;
        if (accept) begin
            case (i_operation)
                OP_START: begin
                    n_window = '0;
                    n_fill   = '0;
                    n_count  = '0;
                    o_q_push.valid    = 1'b1;
                    o_q_push.cmd.kind = CMD_CLEAR;
                end
                OP_SYMBOL: begin
                    n_window = shifted[WIN_BITS-1:0];
                    if (r_fill < FILL_BITS'(KMER_LEN)) begin
                        n_fill = r_fill + 1'b1;
                    end
                    if (r_count != LENGTH_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                    // window is complete once this symbol makes it KMER_LEN long
                    o_q_push.valid       = (r_fill >= FILL_BITS'(KMER_LEN - 1));
                    o_q_push.cmd.kind    = CMD_SET;
                    o_q_push.cmd.addr    = CMD_AW'(kmer_ext >> BIT_IDX_BITS);
                    o_q_push.cmd.bit_idx = kmer_ext[BIT_IDX_BITS-1:0];
                end
                OP_READ: begin
                    o_q_push.valid    = 1'b1;
                    o_q_push.cmd.kind = CMD_READ;
                    o_q_push.cmd.addr = CMD_AW'(i_word_address);
                end
                default: begin
                    o_q_push.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_a <= 2'd0;
            r_code_c <= 2'd1;
            r_code_g <= 2'd2;
            r_code_t <= 2'd3;
            r_window <= '0;
            r_fill   <= '0;
            r_count  <= '0;
        end else begin
            r_window <= n_window;
            r_fill   <= n_fill;
            r_count  <= n_count;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CODE_A: r_code_a <= i_cfg_data;
                    REG_CODE_C: r_code_c <= i_cfg_data;
                    REG_CODE_G: r_code_g <= i_cfg_data;
                    REG_CODE_T: r_code_t <= i_cfg_data;
                    default:    r_code_a <= r_code_a;
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/dkpb_cmd_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dkpb_cmd_queue: short command queue between front and back
// Circular buffer of CQ_DEPTH commands; lets either side stall on its own.
// ============================================================================
module dkpb_cmd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dkpb_pkg::t_cmd_slot  i_push,
    output logic                 o_full,
    output dkpb_pkg::t_cmd_slot  o_head,
    input  logic                 i_pop
);
    import dkpb_pkg::*;

    t_cmd              r_buf [CQ_DEPTH];
    logic [CQ_PW-1:0]  r_wr, r_rd;
    logic [CQ_CW-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_full       = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_buf[r_rd];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/dkpb_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dkpb_back: bitmap store and command execution
// Two-stage read-modify-write on the bitmap memory with write forwarding,
// a clearing sweep for start and after reset, and a two-entry result queue.
// ============================================================================
module dkpb_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dkpb_pkg::t_cmd_slot                 i_head,
    output logic                                o_cmd_pop,
    output dkpb_pkg::t_back_status              o_status,
    output logic                                empty,
    input  logic                                pop,
    output logic [dkpb_pkg::WORD_BITS-1:0]      o_bitmap_word,
    output logic [dkpb_pkg::LENGTH_BITS-1:0]    o_sequence_length
);
    import dkpb_pkg::*;

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    t_back_state          r_state, n_state;
    logic [MEM_AW-1:0]    r_clr_addr;

    t_cmd                 r_s2;
    logic                 r_s2_valid;
    logic                 r_fwd_hit;
    logic [WORD_BITS-1:0] r_fwd_data;

    logic [WORD_BITS-1:0]   r_res_word [2];
    logic [LENGTH_BITS-1:0] r_res_len  [2];
    logic                   r_res_wr, r_res_rd;
    logic [1:0]             r_res_cnt;

    logic [WORD_BITS-1:0] merged, set_data, mem_wdata;
    logic [MEM_AW-1:0]    mem_waddr;
    logic                 mem_we, issue, s2_set, s2_read, res_full, adv;
    logic                 res_push, res_pop, in_range, clr_last;

    assign merged   = r_fwd_hit ? r_fwd_data : r_rdata;
    assign set_data = merged | (WORD_BITS'(1) << r_s2.bit_idx);
    assign s2_set   = r_s2_valid && (r_s2.kind == CMD_SET);
    assign s2_read  = r_s2_valid && (r_s2.kind == CMD_READ);
    assign res_full = (r_res_cnt == 2'd2);
    assign adv      = !(s2_read && res_full);
    assign res_push = s2_read && !res_full;
    assign in_range = (32'(r_s2.addr) < 32'(NUM_WORDS));
    assign clr_last = (r_clr_addr == MEM_AW'(NUM_WORDS - 1));

    always_comb begin
        n_state   = r_state;
        issue     = 1'b0;
        o_cmd_pop = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_s2.addr[MEM_AW-1:0];
        mem_wdata = set_data;
        case (r_state)
            BK_RUN: begin
                mem_we = s2_set;
                if (adv && i_head.valid) begin
                    if (i_head.cmd.kind != CMD_CLEAR) begin
                        issue     = 1'b1;
                        o_cmd_pop = 1'b1;
                    end else if (!r_s2_valid) begin
                        o_cmd_pop = 1'b1;
                        n_state   = BK_CLEAR;
                    end
                end
            end
            BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (clr_last) begin
                    n_state = BK_RUN;
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR && !clr_last) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end else begin
                r_clr_addr <= '0;
            end
        end
    end

    // Bitmap memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            r_rdata <= r_mem[i_head.cmd.addr[MEM_AW-1:0]];
        end
    end

    // Second stage; forward the word written at the same edge as our read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= issue;
            if (issue) begin
                r_fwd_hit <= s2_set && (r_s2.addr == i_head.cmd.addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2       <= i_head.cmd;
            r_fwd_data <= set_data;
        end
    end

    // Result queue
    assign empty             = (r_res_cnt == 2'd0);
    assign res_pop           = pop && !empty;
    assign o_bitmap_word     = r_res_word[r_res_rd];
    assign o_sequence_length = r_res_len[r_res_rd];

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res_word[r_res_wr] <= in_range ? merged : '0;
            r_res_len[r_res_wr]  <= r_s2.seq_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr  <= 1'b0;
            r_res_rd  <= 1'b0;
            r_res_cnt <= 2'd0;
        end else begin
            if (res_push) r_res_wr <= ~r_res_wr;
            if (res_pop)  r_res_rd <= ~r_res_rd;
            case ({res_push, res_pop})
                2'b10:   r_res_cnt <= r_res_cnt + 1'b1;
                2'b01:   r_res_cnt <= r_res_cnt - 1'b1;
                default: r_res_cnt <= r_res_cnt;
            endcase
        end
    end

    assign o_status.clearing = (r_state == BK_CLEAR);
    assign o_status.s2_valid = r_s2_valid;

endmodule

// ===== rtl/core/dna_kmer_presence_bitmap.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dna_kmer_presence_bitmap: 2-bit k-mer presence bitmap over a DNA stream
// Maps characters to codes, keeps an 11-symbol window and marks every
// window value seen in a 4^11-bit bitmap, readable one 64-bit word at a time.
// ============================================================================
// Symbol and read words are taken one per cycle, back to back, while full is
// low. A read word goes through the command queue, the memory read stage and
// the result queue. A start word clears the bitmap by sweeping its memory one
// word per cycle over NUM_WORDS words (65536 at the default sizes); the same
// sweep runs after reset. While it runs no command leaves the queue, so full
// stays high once it rises; configuration writes are still taken. One write
// port and the read-modify-write on it set the one-per-cycle figure.
// ============================================================================
module dna_kmer_presence_bitmap (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dkpb_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dkpb_pkg::CODE_BITS-1:0]      i_cfg_data,
    // input words
    input  logic                                push,
    output logic                                full,
    input  logic [dkpb_pkg::OP_BITS-1:0]        i_operation,
    input  logic [dkpb_pkg::SYMBOL_BITS-1:0]    i_symbol,
    input  logic [dkpb_pkg::IN_ADDR_BITS-1:0]   i_word_address,
    // result words
    output logic                                empty,
    input  logic                                pop,
    output logic [dkpb_pkg::WORD_BITS-1:0]      o_bitmap_word,
    output logic [dkpb_pkg::LENGTH_BITS-1:0]    o_sequence_length
);
    import dkpb_pkg::*;

    t_cmd_slot    q_push;   // front -> queue
    t_cmd_slot    q_head;   // queue -> back
    logic         cmd_pop;
    t_back_status bk_status;

    // Front: characters to codes, window, length count, command build.
    // Full is the queue's full flag, so the front never stalls on its own.
    dkpb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_q_full       (full),
        .i_operation    (i_operation),
        .i_symbol       (i_symbol),
        .i_word_address (i_word_address),
        .o_q_push       (q_push)
    );

    // Short queue decoupling the front from the memory pipeline
    dkpb_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (full),
        .o_head  (q_head),
        .i_pop   (cmd_pop)
    );

    // Back: bitmap memory, set/read pipeline, clearing sweep, result queue
    dkpb_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (q_head),
        .o_cmd_pop         (cmd_pop),
        .o_status          (bk_status),
        .empty             (empty),
        .pop               (pop),
        .o_bitmap_word     (o_bitmap_word),
        .o_sequence_length (o_sequence_length)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // The back end only takes a command that is there
    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> q_head.valid)
        else $error("command popped from empty queue");

    // Nothing is issued to the memory while the sweep owns the write port
    a_no_issue_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_status.clearing |-> (!cmd_pop && !bk_status.s2_valid))
        else $error("command issued during clearing sweep");

    // A sweep only begins with the pipeline drained
    a_clear_starts_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(bk_status.clearing) |-> !$past(bk_status.s2_valid))
        else $error("clearing sweep started with a pending write");

    // No result waits right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule

// ===== verif/dna_kmer_presence_bitmap_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dna_kmer_presence_bitmap_checker: scoreboard for the k-mer presence bitmap
// Watches the code register channel and both word queues. It keeps its own
// window, length count and sparse copy of the bitmap. It predicts every read
// word and compares each popped word with the oldest prediction.
// ============================================================================
module dna_kmer_presence_bitmap_checker
    import dkpb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CODE_BITS-1:0]     i_cfg_data,
    input  logic                     i_push,
    input  logic                     i_full,
    input  logic [OP_BITS-1:0]       i_operation,
    input  logic [SYMBOL_BITS-1:0]   i_symbol,
    input  logic [IN_ADDR_BITS-1:0]  i_word_address,
    input  logic                     i_empty,
    input  logic                     i_pop,
    input  logic [WORD_BITS-1:0]     i_bitmap_word,
    input  logic [LENGTH_BITS-1:0]   i_sequence_length,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [WORD_BITS-1:0]   word;
        logic [LENGTH_BITS-1:0] length;
    } t_read_word;

    logic [CODE_BITS-1:0]   char_code [4];
    logic [WIN_BITS-1:0]    kmer_value;
    logic [FILL_BITS-1:0]   kmer_fill;
    logic [LENGTH_BITS-1:0] seq_length;
    logic [WORD_BITS-1:0]   seen_words [int unsigned];  // absent entry = all zeros
    t_read_word             expected_reads [$];

    int fail_total    = 0;
    int checked_total = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_total++;
        if (fail_total <= PRINT_CAP)
            $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
    endtask

    task automatic clear_sequence();
        kmer_value = '0;
        kmer_fill  = '0;
        seq_length = '0;
        seen_words.delete();
    endtask

    task automatic absorb_symbol(input logic [SYMBOL_BITS-1:0] sym);
        logic [CODE_BITS-1:0] code;
        int unsigned          word_idx;
        logic [WORD_BITS-1:0] bits;
        case (sym)
            CHAR_A:  code = char_code[REG_CODE_A];
            CHAR_C:  code = char_code[REG_CODE_C];
            CHAR_G:  code = char_code[REG_CODE_G];
            CHAR_T:  code = char_code[REG_CODE_T];
            default: code = '0;
        endcase
        kmer_value = {kmer_value[WIN_BITS-CODE_BITS-1:0], code};
        if (kmer_fill < KMER_LEN)
            kmer_fill = kmer_fill + 1'b1;
        if (seq_length != LENGTH_MAX)
            seq_length = seq_length + 1'b1;
        if (kmer_fill >= KMER_LEN) begin
            word_idx = int'(kmer_value >> BIT_IDX_BITS);
            if (word_idx < NUM_WORDS) begin
                bits = seen_words.exists(word_idx) ? seen_words[word_idx] : '0;
                bits[kmer_value[BIT_IDX_BITS-1:0]] = 1'b1;
                seen_words[word_idx] = bits;
            end
        end
    endtask

    function automatic t_read_word predict_read(input logic [IN_ADDR_BITS-1:0] addr);
        t_read_word r;
        int unsigned idx;
        idx      = int'(addr);
        r.word   = (idx < NUM_WORDS && seen_words.exists(idx)) ? seen_words[idx] : '0;
        r.length = seq_length;
        return r;
    endfunction

    task automatic check_result();
        t_read_word want;
        if (expected_reads.size() == 0) begin
            report_mismatch("unexpected result word", 64'(i_bitmap_word), '0);
        end else begin
            want = expected_reads.pop_front();
            checked_total++;
            if (i_bitmap_word !== want.word)
                report_mismatch("bitmap_word", 64'(i_bitmap_word), 64'(want.word));
            if (i_sequence_length !== want.length)
                report_mismatch("sequence_length", 64'(i_sequence_length),
                                64'(want.length));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_code[REG_CODE_A] = 2'd0;
            char_code[REG_CODE_C] = 2'd1;
            char_code[REG_CODE_G] = 2'd2;
            char_code[REG_CODE_T] = 2'd3;
            clear_sequence();
            expected_reads.delete();
        end else begin
            if (i_pop && !i_empty)
                check_result();
            if (i_cfg_valid && i_cfg_ready)
                char_code[i_cfg_index] = i_cfg_data;
            if (i_push && !i_full) begin
                case (i_operation)
                    OP_START:  clear_sequence();
                    OP_SYMBOL: absorb_symbol(i_symbol);
                    OP_READ:   expected_reads.push_back(predict_read(i_word_address));
                    default:   ;  // unused code: no effect
                endcase
            end
        end
        o_pending    <= expected_reads.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
    end

endmodule

// ===== verif/dna_kmer_presence_bitmap_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dna_kmer_presence_bitmap_tb: regression for the k-mer presence bitmap
// Directed words first, then phases of random DNA streams under different
// code maps, with random gaps on both queues. Checking is done by a separate
// scoreboard module; this top only drives stimulus and gives the verdict.
// ============================================================================
module dna_kmer_presence_bitmap_tb;
    import dkpb_pkg::*;

    // Unused operation code, must be ignored by the block
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 1900;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = RANDOM_ITEMS / NUM_PHASES;
    localparam int MAX_RND_STARTS = 6;      // each start costs a full clear sweep
    localparam int DRAIN_CYCLES   = 16;
    localparam int END_CYCLES     = 20;
    // Longest quiet stretch in a good run is one clear sweep plus a long gap;
    // the limit is four times the sweep length.
    localparam int WATCHDOG_LIMIT = 4 * NUM_WORDS;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_cfg_valid    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index    = '0;
    logic [CODE_BITS-1:0]     i_cfg_data     = '0;
    logic                     push           = 1'b0;
    logic [OP_BITS-1:0]       i_operation    = '0;
    logic [SYMBOL_BITS-1:0]   i_symbol       = '0;
    logic [IN_ADDR_BITS-1:0]  i_word_address = '0;
    logic                     pop            = 1'b0;

    logic                     o_cfg_ready;
    logic                     full;
    logic                     empty;
    logic [WORD_BITS-1:0]     o_bitmap_word;
    logic [LENGTH_BITS-1:0]   o_sequence_length;

    int chk_fail_count;
    int chk_pending;
    int chk_checked;

    // Stretches with no idling on either side
    logic calm = 1'b0;

    // Stimulus bookkeeping, for the summary and for aiming reads
    int n_symbols    = 0;
    int n_reads      = 0;
    int n_starts     = 0;
    int n_ignored    = 0;
    int n_cfg_writes = 0;
    int starts_left  = MAX_RND_STARTS;

    logic [CODE_BITS-1:0]   cur_codes [4];
    logic [WIN_BITS-1:0]    aim_window = '0;   // last symbols sent, to aim reads
    logic [SYMBOL_BITS-1:0] dna_chars [4];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    dna_kmer_presence_bitmap u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .push              (push),
        .full              (full),
        .i_operation       (i_operation),
        .i_symbol          (i_symbol),
        .i_word_address    (i_word_address),
        .empty             (empty),
        .pop               (pop),
        .o_bitmap_word     (o_bitmap_word),
        .o_sequence_length (o_sequence_length)
    );

    dna_kmer_presence_bitmap_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_push            (push),
        .i_full            (full),
        .i_operation       (i_operation),
        .i_symbol          (i_symbol),
        .i_word_address    (i_word_address),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_bitmap_word     (o_bitmap_word),
        .i_sequence_length (o_sequence_length),
        .o_fail_count      (chk_fail_count),
        .o_pending         (chk_pending),
        .o_checked         (chk_checked)
    );

    // ------------------------------------------------------------------------
    // Gap lengths: mostly none or short, now and then a long one
    // ------------------------------------------------------------------------
    function automatic int idle_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Character map as currently programmed; only used to aim reads at
    // words that are likely to hold set bits.
    function automatic logic [CODE_BITS-1:0] aim_code(input logic [SYMBOL_BITS-1:0] sym);
        case (sym)
            CHAR_A:  return cur_codes[REG_CODE_A];
            CHAR_C:  return cur_codes[REG_CODE_C];
            CHAR_G:  return cur_codes[REG_CODE_G];
            CHAR_T:  return cur_codes[REG_CODE_T];
            default: return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: pop may stall after a taken word, plus odd random drops
    // ------------------------------------------------------------------------
    logic result_taken = 1'b0;
    int   pop_hold     = 0;
    int   pop_gap;

    always @(posedge i_clk)
        result_taken <= pop && !empty;

    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end else if (result_taken) begin
            pop_gap  = idle_gap();
            pop      <= (pop_gap == 0);
            pop_hold <= (pop_gap > 0) ? pop_gap - 1 : 0;
        end else begin
            pop <= calm || ($urandom_range(0, 7) != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any cycle that moves a word on any channel restarts the count
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("dna_kmer_presence_bitmap regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Present one word at the falling edge and hold it until taken. When no
    // gap follows, push stays high and the next call just changes the fields.
    task automatic send_word(input logic [OP_BITS-1:0] op,
                             input logic [SYMBOL_BITS-1:0] sym,
                             input logic [IN_ADDR_BITS-1:0] addr);
        int gap;
        i_operation    <= op;
        i_symbol       <= sym;
        i_word_address <= addr;
        push           <= 1'b1;
        do @(posedge i_clk); while (full);
        case (op)
            OP_START: begin
                n_starts++;
                aim_window = '0;
            end
            OP_SYMBOL: begin
                n_symbols++;
                aim_window = {aim_window[WIN_BITS-CODE_BITS-1:0], aim_code(sym)};
            end
            OP_READ: n_reads++;
            default: n_ignored++;
        endcase
        gap = idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            push           <= 1'b0;
            i_operation    <= OP_BITS'($urandom_range(0, 3));   // idle fields carry noise
            i_symbol       <= SYMBOL_BITS'($urandom_range(0, 255));
            i_word_address <= IN_ADDR_BITS'($urandom_range(0, 65535));
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_symbol(input logic [SYMBOL_BITS-1:0] sym);
        send_word(OP_SYMBOL, sym, IN_ADDR_BITS'($urandom_range(0, 65535)));
    endtask

    task automatic send_read(input logic [IN_ADDR_BITS-1:0] addr);
        send_word(OP_READ, SYMBOL_BITS'($urandom_range(0, 255)), addr);
    endtask

    // Word that holds the bit of the latest window
    function automatic logic [IN_ADDR_BITS-1:0] aim_address();
        return IN_ADDR_BITS'(aim_window >> BIT_IDX_BITS);
    endfunction

    // Drop push, let every predicted word come out, let the command queue
    // and the back end go idle, then settle a little longer.
    task automatic wait_quiet(input int settle);
        push <= 1'b0;
        while (chk_pending != 0) @(posedge i_clk);
        while (u_top.q_head.valid || u_top.bk_status.s2_valid ||
               u_top.bk_status.clearing)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CODE_BITS-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_codes[idx] = val;
        n_cfg_writes++;
        @(negedge i_clk);
    endtask

    task automatic load_codes(input logic [CODE_BITS-1:0] a, input logic [CODE_BITS-1:0] c,
                              input logic [CODE_BITS-1:0] g, input logic [CODE_BITS-1:0] t);
        cfg_write(REG_CODE_A, a);
        cfg_write(REG_CODE_C, c);
        cfg_write(REG_CODE_G, g);
        cfg_write(REG_CODE_T, t);
        i_cfg_valid <= 1'b0;
    endtask

    // One random word. Mostly clean DNA with reads mixed in; some noise
    // characters, the odd unused operation and a rare start.
    task automatic random_word(output bit counted);
        int r;
        logic [IN_ADDR_BITS-1:0] addr;
        r       = $urandom_range(0, 999);
        counted = 1'b1;
        if (r < 20) begin
            send_word(OP_UNUSED, SYMBOL_BITS'($urandom_range(0, 255)),
                      IN_ADDR_BITS'($urandom_range(0, 65535)));
            counted = 1'b0;
        end else if (r < 22 && starts_left > 0) begin
            starts_left--;
            send_word(OP_START, SYMBOL_BITS'($urandom_range(0, 255)),
                      IN_ADDR_BITS'($urandom_range(0, 65535)));
        end else if (r < 222) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                addr = aim_address();
            else if (r < 58)
                addr = '0;
            else if (r < 66)
                addr = '1;
            else
                addr = IN_ADDR_BITS'($urandom_range(0, 65535));
            send_read(addr);
        end else if (r < 880) begin
            send_symbol(dna_chars[2'($urandom_range(0, 3))]);
        end else begin
            send_symbol(SYMBOL_BITS'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int  done;
        bit  counted;
        dna_chars[0] = CHAR_A;
        dna_chars[1] = CHAR_C;
        dna_chars[2] = CHAR_G;
        dna_chars[3] = CHAR_T;
        cur_codes[REG_CODE_A] = 2'd0;
        cur_codes[REG_CODE_C] = 2'd1;
        cur_codes[REG_CODE_G] = 2'd2;
        cur_codes[REG_CODE_T] = 2'd3;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Code registers are taken during the clear sweep after reset
        load_codes(2'd0, 2'd1, 2'd2, 2'd3);

        // --- directed part ---
        // empty bitmap at both ends of the address range
        send_read('0);
        send_read('1);
        // one symbol short of a full window: nothing may be marked yet
        for (int i = 0; i < KMER_LEN - 1; i++)
            send_symbol(dna_chars[2'(i % 4)]);
        send_read(aim_address());
        // window now complete, its bit must show
        send_symbol(CHAR_G);
        send_read(aim_address());
        // unused operation, then characters outside ACGT map to code zero
        send_word(OP_UNUSED, '1, '1);
        send_symbol("N");
        send_symbol('1);
        send_symbol('0);
        send_read(aim_address());
        // start clears bitmap and length
        send_word(OP_START, '0, '0);
        send_read(aim_address());
        send_read('0);

        // --- random phases, each under its own code map ---
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_quiet(DRAIN_CYCLES);
            case (ph)
                0:       load_codes(2'd0, 2'd1, 2'd2, 2'd3);
                1:       load_codes(2'd0, 2'd0, 2'd0, 2'd0);
                2:       load_codes(2'd3, 2'd3, 2'd3, 2'd3);
                3:       load_codes(2'd3, 2'd2, 2'd1, 2'd0);
                default: load_codes(CODE_BITS'($urandom_range(0, 3)),
                                    CODE_BITS'($urandom_range(0, 3)),
                                    CODE_BITS'($urandom_range(0, 3)),
                                    CODE_BITS'($urandom_range(0, 3)));
            endcase
            calm = (ph == 1 || ph == 6);
            if ((ph % 2 == 0) && ph > 0 && starts_left > 0) begin
                starts_left--;
                send_word(OP_START, SYMBOL_BITS'($urandom_range(0, 255)),
                          IN_ADDR_BITS'($urandom_range(0, 65535)));
            end
            done = 0;
            while (done < PHASE_ITEMS) begin
                random_word(counted);
                if (counted)
                    done++;
            end
        end
        calm = 1'b0;

        wait_quiet(END_CYCLES);

        $display("covered %0d symbols, %0d reads (%0d checked), %0d starts, %0d ignored",
                 n_symbols, n_reads, chk_checked, n_starts, n_ignored);
        $display("over %0d code map settings (%0d register writes), zero and three maps included",
                 NUM_PHASES + 1, n_cfg_writes);
        if (chk_fail_count == 0)
            $display("dna_kmer_presence_bitmap regression: pass");
        else
            $display("dna_kmer_presence_bitmap regression: fail");
        $finish;
    end

endmodule
